// ===== hdl/mwuc_pkg.sv =====
// mwuc_pkg: shared types, constants and helpers for the clamped momentum weight update block
// no dependencies; used by mwuc_store and momentum_weight_update_clamped

package mwuc_pkg;

  // field widths
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ETA_W    = 24;
  localparam int unsigned ALPHA_W  = 17;
  localparam int unsigned CFG_IDX_W = 2;

  // default number of momentum entries
  localparam int unsigned WEIGHT_COUNT_DEF = 1024;

  // register reset values
  localparam logic [ETA_W-1:0]          ETA_RST     = 24'd655360;
  localparam logic [ALPHA_W-1:0]        ALPHA_RST   = 17'd32768;
  localparam logic signed [WORD_W-1:0]  FLOOR_RST   = 32'sh8000_0000;
  localparam logic signed [WORD_W-1:0]  CEILING_RST = 32'sh7fff_ffff;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARNING_RATE  = 2'd0,
    CFG_MOMENTUM_GAIN  = 2'd1,
    CFG_WEIGHT_FLOOR   = 2'd2,
    CFG_WEIGHT_CEILING = 2'd3
  } cfg_idx_e;

  // input word
  typedef struct packed {
    logic [IDX_W-1:0]         weight_index;
    logic signed [WORD_W-1:0] weight_in;
    logic signed [WORD_W-1:0] slope_in;
    logic                     slope_invalid;
  } in_word_t;

  // output word
  typedef struct packed {
    logic signed [WORD_W-1:0] weight_out;
    logic signed [WORD_W-1:0] slope_out;
    logic                     skipped;
  } out_word_t;

  // request from the pipeline to the momentum store
  typedef struct packed {
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_idx;
    logic                     wr_en;
    logic [IDX_W-1:0]         wr_idx;
    logic signed [WORD_W-1:0] wr_data;
  } store_req_t;

  // width of the exact change sum before saturation
  localparam int unsigned SUM_W = 42;

  // saturate a wide signed sum to 32 bits
  function automatic logic signed [WORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(CEILING_RST);
    lo = SUM_W'(FLOOR_RST);
    if (v > hi) begin
      sat32 = CEILING_RST;
    end else if (v < lo) begin
      sat32 = FLOOR_RST;
    end else begin
      sat32 = v[WORD_W-1:0];
    end
  endfunction

endpackage

// ===== hdl/mwuc_store.sv =====
// mwuc_store: momentum store, one synchronous ram with registered read and a clearing sweep
// depends on mwuc_pkg

module mwuc_store #(
  parameter int unsigned WEIGHT_COUNT = mwuc_pkg::WEIGHT_COUNT_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  mwuc_pkg::store_req_t             req_i,
  output logic signed [mwuc_pkg::WORD_W-1:0] rd_data_o,
  output logic                             busy_o
);

  // only entries that a 10-bit index can reach are stored
  localparam int unsigned IdxSpan = 1 << mwuc_pkg::IDX_W;
  localparam int unsigned Depth   = (WEIGHT_COUNT < IdxSpan) ? WEIGHT_COUNT : IdxSpan;
  localparam int unsigned AddrW   = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW    = AddrW + 1;

  logic signed [mwuc_pkg::WORD_W-1:0] mem [Depth];
  logic signed [mwuc_pkg::WORD_W-1:0] rd_data_q;
  logic [CntW-1:0]                    clr_cnt_q;
  logic [CntW-1:0]                    clr_cnt_d;
  logic                               busy;

  // clearing sweep after reset, one entry per cycle
  assign busy      = (clr_cnt_q != CntW'(Depth));
  assign clr_cnt_d = busy ? clr_cnt_q + CntW'(1) : clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else begin
      clr_cnt_q <= clr_cnt_d;
    end
  end

  // write port: sweep first, then pipeline write-back
  always_ff @(posedge clk_i) begin
    if (busy) begin
      mem[clr_cnt_q[AddrW-1:0]] <= '0;
    end else if (req_i.wr_en) begin
      mem[req_i.wr_idx[AddrW-1:0]] <= req_i.wr_data;
    end
  end

  // read port, data registered and held until the next read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_idx[AddrW-1:0]];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy;

endmodule

// ===== hdl/momentum_weight_update_clamped.sv =====
// momentum_weight_update_clamped: top level, config registers and the update pipeline
// depends on mwuc_pkg and mwuc_store
//
// Takes one word per cycle when not stalled and returns one word per input word, in order;
// it passes registers s1, s2, s3 and out_q: the store is read on the taking edge, then come
// multiply, change and write-back, and weight add and clamp. Two words in a row with the
// same in-range index, the first with a valid slope, are not taken back to back: the second
// waits until the first leaves stage 1, as the first's change is formed in the cycle the
// second would need it; any later overlap is covered by forwarding from the write-back
// stage. A stalled output holds the whole pipeline. After reset the momentum store is swept
// to zero, one entry per cycle over min(WEIGHT_COUNT, 1024) entries, 1024 by default, and no
// word is taken until the sweep ends; configuration writes are taken at any time.

module momentum_weight_update_clamped #(
  parameter int unsigned WEIGHT_COUNT = mwuc_pkg::WEIGHT_COUNT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  mwuc_pkg::in_word_t                in_data_i,
  // output channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output mwuc_pkg::out_word_t               out_data_o,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [mwuc_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mwuc_pkg::WORD_W-1:0]       cfg_wdata_i
);

  localparam int unsigned W     = mwuc_pkg::WORD_W;
  localparam int unsigned IW    = mwuc_pkg::IDX_W;
  localparam int unsigned EtaPW = mwuc_pkg::ETA_W + 1 + W;
  localparam int unsigned AlpPW = mwuc_pkg::ALPHA_W + 1 + W;
  localparam int unsigned SW    = mwuc_pkg::SUM_W;

  // configuration registers
  logic [mwuc_pkg::ETA_W-1:0]   eta_q;
  logic [mwuc_pkg::ALPHA_W-1:0] alpha_q;
  logic signed [W-1:0]          floor_q;
  logic signed [W-1:0]          ceil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eta_q   <= mwuc_pkg::ETA_RST;
      alpha_q <= mwuc_pkg::ALPHA_RST;
      floor_q <= mwuc_pkg::FLOOR_RST;
      ceil_q  <= mwuc_pkg::CEILING_RST;
    end else if (cfg_we_i) begin
      case (mwuc_pkg::cfg_idx_e'(cfg_idx_i))
        mwuc_pkg::CFG_LEARNING_RATE:  eta_q   <= cfg_wdata_i[mwuc_pkg::ETA_W-1:0];
        mwuc_pkg::CFG_MOMENTUM_GAIN:  alpha_q <= cfg_wdata_i[mwuc_pkg::ALPHA_W-1:0];
        mwuc_pkg::CFG_WEIGHT_FLOOR:   floor_q <= cfg_wdata_i;
        mwuc_pkg::CFG_WEIGHT_CEILING: ceil_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline registers
  logic                s1_v_q, s2_v_q, s3_v_q, out_v_q;
  mwuc_pkg::in_word_t  s1_q;
  logic                s1_inr_q;
  logic [IW-1:0]       s2_idx_q;
  logic signed [W-1:0] s2_weight_q;
  logic signed [W-1:0] s2_slope_q;
  logic                s2_skip_q;
  logic                s2_inr_q;
  logic signed [EtaPW-1:0] s2_peta_q;
  logic signed [AlpPW-1:0] s2_palpha_q;
  logic [IW-1:0]       s3_idx_q;
  logic signed [W-1:0] s3_weight_q;
  logic signed [W-1:0] s3_slope_q;
  logic signed [W-1:0] s3_change_q;
  logic                s3_skip_q;
  logic                s3_inr_q;
  mwuc_pkg::out_word_t out_q;

  mwuc_pkg::store_req_t store_req;
  logic signed [W-1:0]  rd_data;
  logic                 store_busy;

  // handshake: global advance, interlock on an adjacent same-index update
  logic advance;
  logic hazard;
  logic accept;
  logic in_inr;

  assign advance = !out_v_q || !out_stall_i;
  assign hazard  = s1_v_q && !s1_q.slope_invalid && s1_inr_q &&
                   (s1_q.weight_index == in_data_i.weight_index);
  assign in_stall_o = store_busy || !advance || hazard;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_inr     = (32'(in_data_i.weight_index) < 32'(WEIGHT_COUNT));

  // stage 1: previous change with forwarding from the write-back stage, then the products
  logic signed [W-1:0]     prev;
  logic signed [EtaPW-1:0] peta;
  logic signed [AlpPW-1:0] palpha;

  always_comb begin
    if (!s1_inr_q) begin
      prev = '0;
    end else if (s3_v_q && !s3_skip_q && s3_inr_q && (s3_idx_q == s1_q.weight_index)) begin
      prev = s3_change_q;
    end else begin
      prev = rd_data;
    end
    peta   = $signed(EtaPW'({1'b0, eta_q})) * EtaPW'($signed(s1_q.slope_in));
    palpha = $signed(AlpPW'({1'b0, alpha_q})) * AlpPW'(prev);
  end

  // stage 2: floor shift, exact sum, saturate to the new change
  logic signed [SW-1:0] chg_sum;
  logic signed [W-1:0]  change;

  always_comb begin
    chg_sum = SW'($signed(s2_peta_q[EtaPW-1:16])) + SW'($signed(s2_palpha_q[AlpPW-1:16]));
    change  = mwuc_pkg::sat32(chg_sum);
  end

  // store interface: read at accept, write-back as stage 2 moves on
  always_comb begin
    store_req.rd_en   = accept;
    store_req.rd_idx  = in_data_i.weight_index;
    store_req.wr_en   = advance && s2_v_q && !s2_skip_q && s2_inr_q;
    store_req.wr_idx  = s2_idx_q;
    store_req.wr_data = change;
  end

  mwuc_store #(
    .WEIGHT_COUNT(WEIGHT_COUNT)
  ) u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (store_req),
    .rd_data_o(rd_data),
    .busy_o   (store_busy)
  );

  // stage 3: weight add, saturate, clamp
  logic signed [W-1:0] w_sat;
  logic signed [W-1:0] w_clamp;
  mwuc_pkg::out_word_t out_d;

  always_comb begin
    w_sat = mwuc_pkg::sat32(SW'(s3_weight_q) + SW'(s3_change_q));
    if (w_sat > ceil_q) begin
      w_clamp = ceil_q;
    end else if (w_sat < floor_q) begin
      w_clamp = floor_q;
    end else begin
      w_clamp = w_sat;
    end
    if (s3_skip_q) begin
      out_d.weight_out = s3_weight_q;
      out_d.slope_out  = s3_slope_q;
      out_d.skipped    = 1'b1;
    end else begin
      out_d.weight_out = w_clamp;
      out_d.slope_out  = '0;
      out_d.skipped    = 1'b0;
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (advance) begin
      s1_v_q  <= accept;
      s2_v_q  <= s1_v_q;
      s3_v_q  <= s2_v_q;
      out_v_q <= s3_v_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_q        <= in_data_i;
      s1_inr_q    <= in_inr;
      s2_idx_q    <= s1_q.weight_index;
      s2_weight_q <= s1_q.weight_in;
      s2_slope_q  <= s1_q.slope_in;
      s2_skip_q   <= s1_q.slope_invalid;
      s2_inr_q    <= s1_inr_q;
      s2_peta_q   <= peta;
      s2_palpha_q <= palpha;
      s3_idx_q    <= s2_idx_q;
      s3_weight_q <= s2_weight_q;
      s3_slope_q  <= s2_slope_q;
      s3_change_q <= change;
      s3_skip_q   <= s2_skip_q;
      s3_inr_q    <= s2_inr_q;
      out_q       <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

endmodule

// ===== bench/testbench.sv =====
// testbench: self-checking bench for momentum_weight_update_clamped
// depends on mwuc_pkg and the block's rtl; mirrors the momentum store and the registers,
// drives directed and random words with random idling on both channels
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned PHASE_WORDS = 200;
  localparam int unsigned PHASE_COUNT = 10;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid;
  logic                in_stall;
  mwuc_pkg::in_word_t  in_data;
  logic                out_valid;
  logic                out_stall;
  mwuc_pkg::out_word_t out_data;
  logic                cfg_we;
  logic [mwuc_pkg::CFG_IDX_W-1:0] cfg_idx;
  logic [mwuc_pkg::WORD_W-1:0]    cfg_wdata;

  // mirror of the registers and of the momentum store
  logic [mwuc_pkg::ETA_W-1:0]          eta_q;
  logic [mwuc_pkg::ALPHA_W-1:0]        alpha_q;
  logic signed [mwuc_pkg::WORD_W-1:0]  floor_q;
  logic signed [mwuc_pkg::WORD_W-1:0]  ceil_q;
  logic signed [mwuc_pkg::WORD_W-1:0]  change_mem [mwuc_pkg::WEIGHT_COUNT_DEF];

  mwuc_pkg::out_word_t weight_results_due[$];
  int        fail_count;
  int        cycle_count;
  int        hold_req;
  bit        hold_active;
  int        burst_left;

  momentum_weight_update_clamped dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run length guard
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // saturate to the signed 32-bit range
  function automatic logic signed [mwuc_pkg::WORD_W-1:0] clip_word(input longint v);
    if (v > longint'(32'sh7fff_ffff)) return 32'sh7fff_ffff;
    if (v < -longint'(64'sd2147483648)) return 32'sh8000_0000;
    return v[mwuc_pkg::WORD_W-1:0];
  endfunction

  // expected output word for one accepted input word, updates the store mirror
  function automatic mwuc_pkg::out_word_t apply_weight_update(input mwuc_pkg::in_word_t w);
    mwuc_pkg::out_word_t                r;
    longint                             prev_chg;
    longint                             eta_term;
    longint                             alpha_term;
    logic signed [mwuc_pkg::WORD_W-1:0] chg;
    logic signed [mwuc_pkg::WORD_W-1:0] wt;
    bit                                 in_range;
    r = '0;
    if (w.slope_invalid) begin
      r.weight_out = w.weight_in;
      r.slope_out  = w.slope_in;
      r.skipped    = 1'b1;
      return r;
    end
    in_range   = w.weight_index < mwuc_pkg::WEIGHT_COUNT_DEF;
    prev_chg   = in_range ? longint'(change_mem[w.weight_index]) : 0;
    // arithmetic shift of a signed product is a floor
    eta_term   = (longint'(eta_q) * longint'($signed(w.slope_in))) >>> 16;
    alpha_term = (longint'(alpha_q) * prev_chg) >>> 16;
    chg        = clip_word(eta_term + alpha_term);
    if (in_range) change_mem[w.weight_index] = chg;
    wt = clip_word(longint'($signed(w.weight_in)) + longint'(chg));
    // ceiling wins when the bounds cross
    if (wt > ceil_q) wt = ceil_q;
    else if (wt < floor_q) wt = floor_q;
    r.weight_out = wt;
    return r;
  endfunction

  // compare each output word with the oldest expected one
  always @(posedge clk_i) begin
    mwuc_pkg::out_word_t want;
    if (rst_ni && out_valid && !out_stall) begin
      if (weight_results_due.size() == 0) begin
        $error("output word with nothing expected: weight_out %0d", $signed(out_data.weight_out));
        fail_count++;
      end else begin
        want = weight_results_due.pop_front();
        if (out_data.weight_out !== want.weight_out) begin
          $error("weight_out: expected %0d, got %0d",
                 $signed(want.weight_out), $signed(out_data.weight_out));
          fail_count++;
        end
        if (out_data.slope_out !== want.slope_out) begin
          $error("slope_out: expected %0d, got %0d",
                 $signed(want.slope_out), $signed(out_data.slope_out));
          fail_count++;
        end
        if (out_data.skipped !== want.skipped) begin
          $error("skipped: expected %0b, got %0b", want.skipped, out_data.skipped);
          fail_count++;
        end
      end
    end
  end

  // receiver stall pattern, with an on-demand long hold-off
  initial begin
    int r;
    int n;
    out_stall   = 1'b0;
    hold_active = 1'b0;
    forever begin
      if (hold_req > 0) begin
        @(negedge clk_i);
        out_stall   = 1'b1;
        hold_active = 1'b1;
        repeat (hold_req) @(negedge clk_i);
        hold_req    = 0;
        hold_active = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        @(negedge clk_i);
        if (r < 50) begin
          out_stall = 1'b0;
          n = $urandom_range(1, 8);
        end else if (r < 85) begin
          out_stall = 1'b1;
          n = $urandom_range(1, 3);
        end else if (r < 93) begin
          out_stall = 1'b0;
          n = $urandom_range(40, 120);
        end else begin
          out_stall = 1'b1;
          n = $urandom_range(10, 30);
        end
        repeat (n - 1) @(negedge clk_i);
      end
    end
  end

  // sender gap: mostly none or short, a few long, some runs with none
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // offer one word after a gap and wait until it is taken
  task automatic send_word(input mwuc_pkg::in_word_t w, input int gap);
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data  = w;
    do @(posedge clk_i); while (in_stall);
    weight_results_due.push_back(apply_weight_update(w));
  endtask

  // drop valid and wait until every expected word is back
  task automatic wait_for_idle();
    @(negedge clk_i);
    in_valid = 1'b0;
    while (weight_results_due.size() != 0) @(posedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input mwuc_pkg::cfg_idx_e idx,
                           input logic [mwuc_pkg::WORD_W-1:0] data);
    @(negedge clk_i);
    in_valid  = 1'b0;
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    case (idx)
      mwuc_pkg::CFG_LEARNING_RATE:  eta_q   = data[mwuc_pkg::ETA_W-1:0];
      mwuc_pkg::CFG_MOMENTUM_GAIN:  alpha_q = data[mwuc_pkg::ALPHA_W-1:0];
      mwuc_pkg::CFG_WEIGHT_FLOOR:   floor_q = data;
      mwuc_pkg::CFG_WEIGHT_CEILING: ceil_q  = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  function automatic mwuc_pkg::in_word_t make_word(input logic [mwuc_pkg::IDX_W-1:0] idx,
                                                   input logic [mwuc_pkg::WORD_W-1:0] wt,
                                                   input logic [mwuc_pkg::WORD_W-1:0] sl,
                                                   input logic inv);
    mwuc_pkg::in_word_t w;
    w.weight_index  = idx;
    w.weight_in     = wt;
    w.slope_in      = sl;
    w.slope_invalid = inv;
    return w;
  endfunction

  // Q16.16 value: extremes, small values near zero or fully random
  function automatic logic [mwuc_pkg::WORD_W-1:0] rand_q16();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2, 3, 4: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      5: return '0;
      default: return $urandom();
    endcase
  endfunction

  // random word; indexes crowd into a small pool to exercise forwarding
  function automatic mwuc_pkg::in_word_t rand_word();
    int r;
    int unsigned u;
    logic [mwuc_pkg::IDX_W-1:0] idx;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      u   = $urandom_range(0, 3);
      idx = u[mwuc_pkg::IDX_W-1:0];
    end else if (r < 55) begin
      idx = '1;
    end else if (r < 60) begin
      idx = '0;
    end else begin
      u   = $urandom_range(0, mwuc_pkg::WEIGHT_COUNT_DEF - 1);
      idx = u[mwuc_pkg::IDX_W-1:0];
    end
    return make_word(idx, rand_q16(), rand_q16(), $urandom_range(0, 9) == 0);
  endfunction

  // reset settings: back-to-back same index, skips and saturation
  task automatic test_default_update();
    send_word(make_word(10'd0, 32'h0, 32'h0001_0000, 1'b0), 0);
    send_word(make_word(10'd0, 32'h0, 32'h0001_0000, 1'b0), 0);
    send_word(make_word(10'd0, 32'h1234_5678, 32'hffff_ffff, 1'b1), 0);
    send_word(make_word(10'd0, 32'h0, 32'hffff_ffff, 1'b0), 0);
    send_word(make_word(10'd1023, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0), 0);
    send_word(make_word(10'd1023, 32'h8000_0000, 32'h8000_0000, 1'b0), 0);
    send_word(make_word(10'd1, 32'h8000_0000, 32'h0, 1'b1), 2);
    send_word(make_word(10'd512, 32'h7fff_ffff, 32'h8000_0000, 1'b0), 0);
    wait_for_idle();
  endtask

  // narrow bounds, then a floor above the ceiling
  task automatic test_clamp_bounds();
    write_reg(mwuc_pkg::CFG_WEIGHT_FLOOR, 32'hffff_0000);
    write_reg(mwuc_pkg::CFG_WEIGHT_CEILING, 32'h0001_0000);
    send_word(make_word(10'd5, 32'h0, 32'h0001_0000, 1'b0), 0);
    send_word(make_word(10'd6, 32'h0, 32'hffff_0000, 1'b0), 0);
    send_word(make_word(10'd7, 32'h0, 32'h0000_0100, 1'b0), 0);
    wait_for_idle();
    write_reg(mwuc_pkg::CFG_WEIGHT_FLOOR, 32'h0002_0000);
    write_reg(mwuc_pkg::CFG_WEIGHT_CEILING, 32'hfffe_0000);
    send_word(make_word(10'd8, 32'h0, 32'h0, 1'b0), 0);
    send_word(make_word(10'd8, 32'hfffd_0000, 32'h0, 1'b0), 0);
    send_word(make_word(10'd9, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0), 1);
    wait_for_idle();
  endtask

  // zero gains, largest gains and a gain of exactly one
  task automatic test_gain_extremes();
    write_reg(mwuc_pkg::CFG_WEIGHT_FLOOR, 32'h8000_0000);
    write_reg(mwuc_pkg::CFG_WEIGHT_CEILING, 32'h7fff_ffff);
    write_reg(mwuc_pkg::CFG_LEARNING_RATE, 32'h0);
    write_reg(mwuc_pkg::CFG_MOMENTUM_GAIN, 32'h0);
    send_word(make_word(10'd0, 32'h0001_0000, 32'h7fff_ffff, 1'b0), 0);
    wait_for_idle();
    write_reg(mwuc_pkg::CFG_LEARNING_RATE, 32'h00ff_ffff);
    write_reg(mwuc_pkg::CFG_MOMENTUM_GAIN, 32'h0001_ffff);
    send_word(make_word(10'd2, 32'h0, 32'h7fff_ffff, 1'b0), 0);
    send_word(make_word(10'd2, 32'h0, 32'h0, 1'b0), 0);
    send_word(make_word(10'd2, 32'h0, 32'h8000_0000, 1'b0), 0);
    wait_for_idle();
    write_reg(mwuc_pkg::CFG_LEARNING_RATE, 32'h0001_0000);
    write_reg(mwuc_pkg::CFG_MOMENTUM_GAIN, 32'h0001_0000);
    send_word(make_word(10'd3, 32'h0, 32'h0001_2345, 1'b0), 0);
    send_word(make_word(10'd3, 32'h0, 32'h0000_0001, 1'b0), 0);
    wait_for_idle();
  endtask

  // receiver holds off long enough for the block to back up into its input
  task automatic test_output_holdoff();
    hold_req = 200;
    while (!hold_active) @(posedge clk_i);
    repeat (40) send_word(rand_word(), 0);
    wait_for_idle();
    repeat (10) send_word(rand_word(), pick_gap());
    wait_for_idle();
  endtask

  // random settings per phase, random words with random gaps
  task automatic test_random_phases();
    int r;
    logic signed [mwuc_pkg::WORD_W-1:0] lo;
    logic signed [mwuc_pkg::WORD_W-1:0] hi;
    logic signed [mwuc_pkg::WORD_W-1:0] tmp;
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      r = $urandom_range(0, 9);
      case (r)
        0: write_reg(mwuc_pkg::CFG_LEARNING_RATE, 32'h0);
        1: write_reg(mwuc_pkg::CFG_LEARNING_RATE, 32'h00ff_ffff);
        2, 3: write_reg(mwuc_pkg::CFG_LEARNING_RATE, $urandom_range(0, 32'h00ff_ffff));
        default: write_reg(mwuc_pkg::CFG_LEARNING_RATE, $urandom_range(0, 32'h0003_0000));
      endcase
      r = $urandom_range(0, 9);
      case (r)
        0: write_reg(mwuc_pkg::CFG_MOMENTUM_GAIN, 32'h0);
        1: write_reg(mwuc_pkg::CFG_MOMENTUM_GAIN, 32'h0001_0000);
        2: write_reg(mwuc_pkg::CFG_MOMENTUM_GAIN, 32'h0001_ffff);
        3: write_reg(mwuc_pkg::CFG_MOMENTUM_GAIN, $urandom_range(0, 32'h0001_ffff));
        default: write_reg(mwuc_pkg::CFG_MOMENTUM_GAIN, $urandom_range(0, 32'h0001_0000));
      endcase
      lo = $urandom();
      hi = $urandom();
      r  = $urandom_range(0, 9);
      if (r < 3) begin
        lo = 32'sh8000_0000;
        hi = 32'sh7fff_ffff;
      end else if (r < 6) begin
        lo = -$signed(32'($urandom_range(0, 32'h0010_0000)));
        hi = $urandom_range(0, 32'h0010_0000);
      end else if (r < 9 && lo > hi) begin
        tmp = lo;
        lo  = hi;
        hi  = tmp;
      end
      write_reg(mwuc_pkg::CFG_WEIGHT_FLOOR, lo);
      write_reg(mwuc_pkg::CFG_WEIGHT_CEILING, hi);
      repeat (PHASE_WORDS) send_word(rand_word(), pick_gap());
      wait_for_idle();
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    fail_count = 0;
    hold_req   = 0;
    burst_left = 0;
    eta_q      = mwuc_pkg::ETA_RST;
    alpha_q    = mwuc_pkg::ALPHA_RST;
    floor_q    = mwuc_pkg::FLOOR_RST;
    ceil_q     = mwuc_pkg::CEILING_RST;
    foreach (change_mem[i]) change_mem[i] = '0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    test_default_update();
    test_clamp_bounds();
    test_gain_extremes();
    test_output_holdoff();
    test_random_phases();

    wait_for_idle();
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
